[rtl/tlpw_pkg.sv]
package tlpw_pkg;

    localparam int MAX_NODES_DEF  = 128;
    localparam int LOG_LEVELS_DEF = 8;
    localparam int IDX_BITS       = 8;
    localparam int WEIGHT_BITS    = 16;
    localparam int SUM_BITS       = 23;
    localparam int NODE_WORD_BITS = 2 * IDX_BITS + WEIGHT_BITS;
    localparam int S_TDATA_BITS   = 56;
    localparam int M_TDATA_BITS   = 32;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [4:0] {
        S_RCLR,
        S_IDLE,
        S_BCLR,
        S_MAXD_RD,
        S_MAXD_CMP,
        S_L0_RD,
        S_L0_WR,
        S_LJ_RD1,
        S_LJ_RD2,
        S_LJ_WR,
        S_QD_U,
        S_QD_V,
        S_QD_CMP,
        S_Q1_RD,
        S_Q1_A,
        S_Q1_D,
        S_Q1_END,
        S_Q2_RU,
        S_Q2_RV,
        S_Q2_CMP,
        S_QF_U,
        S_QF_V,
        S_QF_END,
        S_DONE
    } tlpw_state_t;

    // floor(log2(d)), 0 for d of 0
    function automatic int floor_log2(input logic [IDX_BITS-1:0] d);
        int r;
        r = 0;
        for (int b = 1; b < IDX_BITS; b++) begin
            if (d[b]) begin
                r = b;
            end
        end
        return r;
    endfunction

endpackage

[rtl/tlpw_node_mem.sv]
module tlpw_node_mem #(
    parameter int AW    = 8,
    parameter int DEPTH = 129
) (
    input  logic                                aclk,
    input  logic                                we,
    input  logic [AW-1:0]                       waddr,
    input  logic [tlpw_pkg::NODE_WORD_BITS-1:0] wdata,
    input  logic [AW-1:0]                       raddr,
    output logic [tlpw_pkg::NODE_WORD_BITS-1:0] rdata
);
    import tlpw_pkg::*;

    logic [NODE_WORD_BITS-1:0] mem [DEPTH];
    logic [NODE_WORD_BITS-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/tlpw_jump_mem.sv]
module tlpw_jump_mem #(
    parameter int AW = 11,
    parameter int DW = 31
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/tree_lca_path_weight_engine_core.sv]
// Load beat: taken in S_IDLE; the beat marked last starts a table build
//   (clear, max-depth pass, levels 0 to top over the n nodes in use).
// Query beat: straight to the result when bad or u == v, else walks the
//   jump table levels top down, one read at a time at its one read port.
// Reset (aresetn low, synchronous): node_count 1, top level 0, then a clear
//   sweep of all 2^(NW+LW) table entries (2048 by default), taking no beat.
module tree_lca_path_weight_engine_core #(
    parameter int MAX_NODES  = tlpw_pkg::MAX_NODES_DEF,
    parameter int LOG_LEVELS = tlpw_pkg::LOG_LEVELS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [tlpw_pkg::IDX_BITS-1:0]     cfg_wdata,     // node_count
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // node_index, parent_index, node_depth, node_weight, query_u, query_v
    input  logic [tlpw_pkg::S_TDATA_BITS-1:0] s_tdata,
    input  logic                              s_tuser,       // opcode
    input  logic                              s_tlast,       // last_node
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // ancestor, path_sum, zero pad
    output logic [tlpw_pkg::M_TDATA_BITS-1:0] m_tdata,
    output logic                              m_tuser        // bad_index
);
    import tlpw_pkg::*;

    localparam int NW = $clog2(MAX_NODES + 1);
    localparam int LW = $clog2(LOG_LEVELS);
    localparam int AW = NW + LW;
    localparam int JW = NW + SUM_BITS;

    tlpw_state_t state_reg, state_next;
    logic [AW-1:0]          cnt_reg, cnt_next;
    logic [NW-1:0]          i_reg, i_next;
    logic [LW-1:0]          j_reg, j_next;
    logic [LW-1:0]          top_reg, top_next;
    logic [IDX_BITS-1:0]    maxd_reg, maxd_next;
    logic [IDX_BITS-1:0]    count_reg, count_next;
    logic [NW-1:0]          u_reg, u_next, v_reg, v_next, a_reg, a_next;
    logic [IDX_BITS-1:0]    du_reg, du_next, dv_reg, dv_next;
    logic [SUM_BITS-1:0]    s_reg, s_next, ret_reg, ret_next;
    logic [NW-1:0]          res_anc_reg, res_anc_next;
    logic                   res_bad_reg, res_bad_next;
    logic                   m_valid_reg, m_valid_next;
    logic [IDX_BITS-1:0]    o_anc_reg, o_anc_next;
    logic [SUM_BITS-1:0]    o_sum_reg, o_sum_next;
    logic                   o_bad_reg, o_bad_next;

    logic [NW-1:0]             nuse;
    logic                      nm_we;
    logic [NW-1:0]             nm_raddr;
    logic [NODE_WORD_BITS-1:0] nm_rdata;
    logic [IDX_BITS-1:0]       nm_par, nm_dep;
    logic [WEIGHT_BITS-1:0]    nm_wt;
    logic                      jm_we;
    logic [AW-1:0]             jm_waddr, jm_raddr;
    logic [JW-1:0]             jm_wdata, jm_rdata;
    logic [NW-1:0]             jm_anc;
    logic [SUM_BITS-1:0]       jm_sum;
    logic [IDX_BITS-1:0]       in_idx, in_par, in_dep, in_u, in_v;
    logic [WEIGHT_BITS-1:0]    in_wt;
    logic [IDX_BITS-1:0]       maxd_new;
    logic [LW-1:0]             top_new;
    logic                      lj_adv, q1_adv;

    assign nuse = (32'(count_reg) > MAX_NODES) ? NW'(MAX_NODES) : NW'(count_reg);

    assign in_idx = s_tdata[7:0];
    assign in_par = s_tdata[15:8];
    assign in_dep = s_tdata[23:16];
    assign in_wt  = s_tdata[39:24];
    assign in_u   = s_tdata[47:40];
    assign in_v   = s_tdata[55:48];

    assign nm_par = nm_rdata[7:0];
    assign nm_dep = nm_rdata[15:8];
    assign nm_wt  = nm_rdata[NODE_WORD_BITS-1:16];
    assign jm_anc = jm_rdata[SUM_BITS +: NW];
    assign jm_sum = jm_rdata[SUM_BITS-1:0];

    assign nm_we = (state_reg == S_IDLE) && s_tvalid && (s_tuser == OP_LOAD)
                   && (in_idx != '0) && (32'(in_idx) <= 32'(nuse));

    assign maxd_new = (nm_dep > maxd_reg) ? nm_dep : maxd_reg;

    always_comb begin
        int lg;
        lg = floor_log2(maxd_new);
        if (lg > LOG_LEVELS - 1) begin
            lg = LOG_LEVELS - 1;
        end
        top_new = LW'(lg);
    end

    tlpw_node_mem #(.AW(NW), .DEPTH(MAX_NODES + 1)) u_node_mem (
        .aclk  (aclk),
        .we    (nm_we),
        .waddr (NW'(in_idx)),
        .wdata ({in_wt, in_dep, in_par}),
        .raddr (nm_raddr),
        .rdata (nm_rdata)
    );

    tlpw_jump_mem #(.AW(AW), .DW(JW)) u_jump_mem (
        .aclk  (aclk),
        .we    (jm_we),
        .waddr (jm_waddr),
        .wdata (jm_wdata),
        .raddr (jm_raddr),
        .rdata (jm_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_RCLR;
            cnt_reg     <= '0;
            top_reg     <= '0;
            count_reg   <= IDX_BITS'(1);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            top_reg     <= top_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        i_reg       <= i_next;
        j_reg       <= j_next;
        maxd_reg    <= maxd_next;
        u_reg       <= u_next;
        v_reg       <= v_next;
        a_reg       <= a_next;
        du_reg      <= du_next;
        dv_reg      <= dv_next;
        s_reg       <= s_next;
        ret_reg     <= ret_next;
        res_anc_reg <= res_anc_next;
        res_bad_reg <= res_bad_next;
        o_anc_reg   <= o_anc_next;
        o_sum_reg   <= o_sum_next;
        o_bad_reg   <= o_bad_next;
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        top_next     = top_reg;
        maxd_next    = maxd_reg;
        count_next   = cfg_we ? cfg_wdata : count_reg;
        u_next       = u_reg;
        v_next       = v_reg;
        a_next       = a_reg;
        du_next      = du_reg;
        dv_next      = dv_reg;
        s_next       = s_reg;
        ret_next     = ret_reg;
        res_anc_next = res_anc_reg;
        res_bad_next = res_bad_reg;
        m_valid_next = m_valid_reg && !m_tready;
        o_anc_next   = o_anc_reg;
        o_sum_next   = o_sum_reg;
        o_bad_next   = o_bad_reg;
        s_tready     = 1'b0;
        nm_raddr     = '0;
        jm_raddr     = '0;
        jm_we        = 1'b0;
        jm_waddr     = '0;
        jm_wdata     = '0;
        lj_adv       = 1'b0;
        q1_adv       = 1'b0;

        unique case (state_reg)
            S_RCLR, S_BCLR: begin
                jm_we    = 1'b1;
                jm_waddr = cnt_reg;
                cnt_next = cnt_reg + 1'b1;
                if (&cnt_reg) begin
                    if (state_reg == S_RCLR || nuse == '0) begin
                        top_next   = '0;
                        state_next = S_IDLE;
                    end else begin
                        i_next     = NW'(1);
                        maxd_next  = '0;
                        state_next = S_MAXD_RD;
                    end
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser == OP_LOAD) begin
                        if (s_tlast) begin
                            cnt_next   = '0;
                            state_next = S_BCLR;
                        end
                    end else begin
                        ret_next     = '0;
                        res_bad_next = 1'b0;
                        u_next       = NW'(in_u);
                        v_next       = NW'(in_v);
                        if (in_u == '0 || 32'(in_u) > 32'(nuse)
                            || in_v == '0 || 32'(in_v) > 32'(nuse)) begin
                            res_anc_next = '0;
                            res_bad_next = 1'b1;
                            state_next   = S_DONE;
                        end else if (in_u == in_v) begin
                            res_anc_next = NW'(in_u);
                            state_next   = S_DONE;
                        end else begin
                            state_next = S_QD_U;
                        end
                    end
                end
            end
            S_MAXD_RD: begin
                nm_raddr   = i_reg;
                state_next = S_MAXD_CMP;
            end
            S_MAXD_CMP: begin
                maxd_next = maxd_new;
                if (i_reg == nuse) begin
                    top_next   = top_new;
                    i_next     = NW'(1);
                    state_next = S_L0_RD;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_MAXD_RD;
                end
            end
            S_L0_RD: begin
                nm_raddr   = i_reg;
                state_next = S_L0_WR;
            end
            S_L0_WR: begin
                // a parent out of range leaves the node a root
                if (nm_par != '0 && 32'(nm_par) <= 32'(nuse)) begin
                    jm_we    = 1'b1;
                    jm_waddr = {i_reg, LW'(0)};
                    jm_wdata = {NW'(nm_par),
                                {(SUM_BITS - WEIGHT_BITS){nm_wt[WEIGHT_BITS-1]}}, nm_wt};
                end
                if (i_reg == nuse) begin
                    i_next = NW'(1);
                    j_next = LW'(1);
                    state_next = (top_reg == '0) ? S_IDLE : S_LJ_RD1;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_L0_RD;
                end
            end
            S_LJ_RD1: begin
                jm_raddr   = {i_reg, j_reg - 1'b1};
                state_next = S_LJ_RD2;
            end
            S_LJ_RD2: begin
                s_next = jm_sum;
                if (jm_anc == '0) begin
                    lj_adv = 1'b1;
                end else begin
                    jm_raddr   = {jm_anc, j_reg - 1'b1};
                    state_next = S_LJ_WR;
                end
            end
            S_LJ_WR: begin
                jm_we    = 1'b1;
                jm_waddr = {i_reg, j_reg};
                jm_wdata = {jm_anc, s_reg + jm_sum};
                lj_adv   = 1'b1;
            end
            S_QD_U: begin
                nm_raddr   = u_reg;
                state_next = S_QD_V;
            end
            S_QD_V: begin
                du_next    = nm_dep;
                nm_raddr   = v_reg;
                state_next = S_QD_CMP;
            end
            S_QD_CMP: begin
                // raise the deeper node first
                if (du_reg < nm_dep) begin
                    u_next  = v_reg;
                    v_next  = u_reg;
                    dv_next = du_reg;
                end else begin
                    dv_next = nm_dep;
                end
                j_next     = top_reg;
                state_next = S_Q1_RD;
            end
            S_Q1_RD: begin
                jm_raddr   = {u_reg, j_reg};
                state_next = S_Q1_A;
            end
            S_Q1_A: begin
                a_next = jm_anc;
                s_next = jm_sum;
                if (jm_anc == '0) begin
                    q1_adv = 1'b1;
                end else begin
                    nm_raddr   = jm_anc;
                    state_next = S_Q1_D;
                end
            end
            S_Q1_D: begin
                if (nm_dep >= dv_reg) begin
                    ret_next = ret_reg + s_reg;
                    u_next   = a_reg;
                end
                q1_adv = 1'b1;
            end
            S_Q1_END: begin
                if (u_reg == v_reg) begin
                    res_anc_next = u_reg;
                    state_next   = S_DONE;
                end else begin
                    j_next     = top_reg;
                    state_next = S_Q2_RU;
                end
            end
            S_Q2_RU: begin
                jm_raddr   = {u_reg, j_reg};
                state_next = S_Q2_RV;
            end
            S_Q2_RV: begin
                a_next     = jm_anc;
                s_next     = jm_sum;
                jm_raddr   = {v_reg, j_reg};
                state_next = S_Q2_CMP;
            end
            S_Q2_CMP: begin
                if (a_reg != '0 && a_reg != jm_anc) begin
                    ret_next = ret_reg + s_reg + jm_sum;
                    u_next   = a_reg;
                    v_next   = jm_anc;
                end
                if (j_reg == '0) begin
                    state_next = S_QF_U;
                end else begin
                    j_next     = j_reg - 1'b1;
                    state_next = S_Q2_RU;
                end
            end
            S_QF_U: begin
                jm_raddr   = {u_reg, LW'(0)};
                state_next = S_QF_V;
            end
            S_QF_V: begin
                a_next     = jm_anc;
                s_next     = jm_sum;
                jm_raddr   = {v_reg, LW'(0)};
                state_next = S_QF_END;
            end
            S_QF_END: begin
                ret_next     = ret_reg + s_reg + jm_sum;
                res_anc_next = a_reg;
                state_next   = S_DONE;
            end
            S_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    o_anc_next   = IDX_BITS'(res_anc_reg);
                    o_sum_next   = ret_reg;
                    o_bad_next   = res_bad_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (lj_adv) begin
            if (i_reg == nuse) begin
                i_next = NW'(1);
                if (j_reg == top_reg) begin
                    state_next = S_IDLE;
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_LJ_RD1;
                end
            end else begin
                i_next     = i_reg + 1'b1;
                state_next = S_LJ_RD1;
            end
        end

        if (q1_adv) begin
            if (j_reg == '0) begin
                state_next = S_Q1_END;
            end else begin
                j_next     = j_reg - 1'b1;
                state_next = S_Q1_RD;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_BITS - IDX_BITS - SUM_BITS){1'b0}}, o_sum_reg, o_anc_reg};
    assign m_tuser  = o_bad_reg;

endmodule
